[design/microwire_serial_eeprom_macros.svh]
// Assertion macros used by the serial EEPROM top level.
`ifndef MICROWIRE_SERIAL_EEPROM_MACROS_SVH
`define MICROWIRE_SERIAL_EEPROM_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define MWEE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define MWEE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/mwee_pkg.sv]
// Types, codes and constants of the serial EEPROM.
`timescale 1ns / 1ps
package mwee_pkg;

	localparam int WORDS_DEF = 64;

	// Bus operation codes of an input beat.
	localparam logic [1:0] OP_LINES = 2'd0;
	localparam logic [1:0] OP_CTRL  = 2'd1;
	localparam logic [1:0] OP_PINS  = 2'd2;

	// Bit positions in the pin levels and line bits.
	localparam int PIN_DIN  = 0;
	localparam int PIN_CLK  = 1;
	localparam int PIN_CS   = 2;
	localparam int PIN_DOUT = 3;

	// Control register bits.
	localparam int CTRL_RESET  = 7;
	localparam int CTRL_ENABLE = 3;

	// Opcode field (command bits 7..6) and extended sub-codes (bits 5..4).
	localparam logic [1:0] OPC_EXT   = 2'b00;
	localparam logic [1:0] OPC_WRITE = 2'b01;
	localparam logic [1:0] OPC_READ  = 2'b10;
	localparam logic [1:0] OPC_ERASE = 2'b11;
	localparam logic [1:0] EXT_EWDS  = 2'b00;
	localparam logic [1:0] EXT_WRAL  = 2'b01;
	localparam logic [1:0] EXT_ERAL  = 2'b10;
	localparam logic [1:0] EXT_EWEN  = 2'b11;

	localparam logic [15:0] ERASED     = 16'hFFFF;
	localparam logic [3:0]  PINS_RESET = 4'b1000;
	localparam logic [4:0]  CMD_BITS   = 5'd8;
	localparam logic [5:0]  DATA_BITS  = 6'd16;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_CMD   = 2'd1,
		PH_READ  = 2'd2,
		PH_WRITE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] value;
	} item_t;

	typedef struct packed {
		logic       vld;
		logic [2:0] read_data;
		logic       enabled;
	} res_t;

	typedef struct packed {
		logic        en;
		logic [15:0] data;
	} wr_t;

endpackage

[design/mwee_in_if.sv]
// Input channel: bus operation beats.
`timescale 1ns / 1ps
interface mwee_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

[design/mwee_out_if.sv]
// Output channel: pin read-back beats.
`timescale 1ns / 1ps
interface mwee_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] read_data;
	logic       enabled;

	modport source (output valid, output read_data, output enabled, input ready);
	modport sink   (input valid, input read_data, input enabled, output ready);
endinterface

[design/mwee_store.sv]
// Word store: synchronous RAM with per-word valid bits so reset reads as erased.
`timescale 1ns / 1ps
module mwee_store #(
	parameter int WORDS = mwee_pkg::WORDS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [$clog2(WORDS)-1:0]   rd_addr,
	output logic [15:0]                rd_data,
	input  logic [$clog2(WORDS)-1:0]   wr_addr,
	input  mwee_pkg::wr_t              wr
);
	import mwee_pkg::*;

	logic [15:0]      mem_q [WORDS];
	logic [WORDS-1:0] vld_q;
	logic [15:0]      rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr_addr] <= wr.data;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	// A word never written since reset is still erased.
	assign rd_data = rd_vld_q ? rd_q : ERASED;

endmodule

[design/mwee_ctrl.sv]
// Protocol controller: sequences read, execute, sweep and hand-off of one beat.
`timescale 1ns / 1ps
module mwee_ctrl #(
	parameter int WORDS = mwee_pkg::WORDS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_vld,
	input  mwee_pkg::item_t            item,
	output logic                       item_rdy,
	input  logic                       slot_free,
	output mwee_pkg::res_t             res,
	output logic [$clog2(WORDS)-1:0]   rd_addr,
	input  logic [15:0]                rd_data,
	output logic [$clog2(WORDS)-1:0]   wr_addr,
	output mwee_pkg::wr_t              wr
);
	import mwee_pkg::*;

	localparam int AW = $clog2(WORDS);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RD    = 5'b00010,
		ST_EX    = 5'b00100,
		ST_SWEEP = 5'b01000,
		ST_PUT   = 5'b10000
	} seq_t;

	seq_t          state_q;
	item_t         item_q;
	phase_t        proto_q, proto_n;
	logic [7:0]    cmd_q, cmd_n, cmd_sh;
	logic [4:0]    cnt_q, cnt_n;
	logic [5:0]    cnt_inc;
	logic [15:0]   latch_q, latch_n, latch_sh;
	logic [3:0]    pins_q, pins_n;
	logic          wp_q, wp_n;
	logic          en_q, en_n;
	logic [2:0]    lines;
	logic          din;
	logic          wr1_en;
	logic [AW-1:0] wr1_addr;
	logic [15:0]   wr1_data;
	logic          sweep_go;
	logic [15:0]   sweep_dat;
	logic [15:0]   swp_dat_q;
	logic [AW-1:0] swp_cnt_q;
	logic [2:0]    res_rd_q;
	logic          res_en_q;

	// The 6-bit address folded into the store; it is below four times the depth.
	function automatic logic [AW-1:0] addr_mod(input logic [5:0] a);
		logic [8:0] r;
		r = {3'b000, a};
		for (int i = 0; i < 3; i++) begin
			if (r >= 9'(WORDS)) begin
				r = r - 9'(WORDS);
			end
		end
		return AW'(r);
	endfunction

	assign lines    = item_q.value[2:0];
	assign din      = lines[PIN_DIN];
	assign cmd_sh   = {cmd_q[6:0], din};
	assign cnt_inc  = {1'b0, cnt_q} + 6'd1;
	assign latch_sh = {latch_q[14:0], din};
	assign rd_addr  = addr_mod(cmd_q[5:0]);

	always_comb begin
		proto_n   = proto_q;
		cmd_n     = cmd_q;
		cnt_n     = cnt_q;
		latch_n   = latch_q;
		pins_n    = pins_q;
		wp_n      = wp_q;
		en_n      = en_q;
		wr1_en    = 1'b0;
		wr1_addr  = addr_mod(cmd_q[5:0]);
		wr1_data  = ERASED;
		sweep_go  = 1'b0;
		sweep_dat = ERASED;
		case (item_q.op)
			OP_LINES: begin
				if (!lines[PIN_CS]) begin
					if (pins_q[PIN_CS]) begin
						proto_n = PH_START;
						cmd_n   = '0;
						cnt_n   = '0;
					end
					pins_n = {1'b1, lines};
				end else if (lines[PIN_CLK] && !pins_q[PIN_CLK]) begin
					pins_n = {pins_q[PIN_DOUT], lines};
					case (proto_q)
						PH_START: begin
							if (din) begin
								proto_n = PH_CMD;
								cmd_n   = '0;
								cnt_n   = '0;
							end
						end
						PH_CMD: begin
							if (cnt_q < CMD_BITS) begin
								cmd_n = cmd_sh;
								cnt_n = cnt_inc[4:0];
								if (cnt_inc[4:0] == CMD_BITS) begin
									case (cmd_sh[7:6])
										OPC_EXT: begin
											case (cmd_sh[5:4])
												EXT_EWDS: begin
													wp_n    = 1'b1;
													proto_n = PH_START;
												end
												EXT_WRAL: begin
													cnt_n   = '0;
													latch_n = '0;
													proto_n = PH_WRITE;
												end
												EXT_ERAL: begin
													sweep_go         = !wp_q;
													pins_n[PIN_DOUT] = 1'b1;
													proto_n          = PH_START;
												end
												EXT_EWEN: begin
													wp_n    = 1'b0;
													proto_n = PH_START;
												end
												default: ;
											endcase
										end
										OPC_WRITE: begin
											cnt_n   = '0;
											latch_n = '0;
											proto_n = PH_WRITE;
										end
										OPC_READ: begin
											cnt_n            = '0;
											proto_n          = PH_READ;
											pins_n[PIN_DOUT] = 1'b0;
										end
										OPC_ERASE: begin
											// While protected the device sits with a full count
											// and ignores clocks until chip select drops.
											if (!wp_q) begin
												wr1_en           = 1'b1;
												wr1_addr         = addr_mod(cmd_sh[5:0]);
												pins_n[PIN_DOUT] = 1'b1;
												proto_n          = PH_START;
											end
										end
										default: ;
									endcase
								end
							end
						end
						PH_READ: begin
							pins_n[PIN_DOUT] = rd_data[~cnt_q[3:0]];
							if (cnt_inc >= DATA_BITS) begin
								cnt_n = '0;
								cmd_n = {OPC_READ, cmd_q[5:0] + 6'd1};
							end else begin
								cnt_n = cnt_inc[4:0];
							end
						end
						PH_WRITE: begin
							latch_n = latch_sh;
							cnt_n   = cnt_inc[4:0];
							if (cnt_inc >= DATA_BITS) begin
								if (!wp_q) begin
									if (cmd_q[6]) begin
										wr1_en   = 1'b1;
										wr1_data = latch_sh;
									end else begin
										sweep_go  = 1'b1;
										sweep_dat = latch_sh;
									end
								end
								pins_n[PIN_DOUT] = 1'b1;
								proto_n          = PH_START;
							end
						end
						default: ;
					endcase
				end else begin
					pins_n = {pins_q[PIN_DOUT], lines};
				end
			end
			OP_CTRL: begin
				if (item_q.value[CTRL_RESET]) begin
					en_n    = 1'b0;
					pins_n  = PINS_RESET;
					wp_n    = 1'b1;
					proto_n = PH_START;
					cmd_n   = '0;
					cnt_n   = '0;
				end else begin
					en_n = item_q.value[CTRL_ENABLE];
				end
			end
			OP_PINS: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			proto_q   <= PH_START;
			cmd_q     <= '0;
			cnt_q     <= '0;
			latch_q   <= '0;
			pins_q    <= PINS_RESET;
			wp_q      <= 1'b1;
			en_q      <= 1'b0;
			swp_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_vld) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_EX;
				end
				ST_EX: begin
					proto_q <= proto_n;
					cmd_q   <= cmd_n;
					cnt_q   <= cnt_n;
					latch_q <= latch_n;
					pins_q  <= pins_n;
					wp_q    <= wp_n;
					en_q    <= en_n;
					if (sweep_go) begin
						swp_cnt_q <= '0;
						state_q   <= ST_SWEEP;
					end else begin
						state_q <= ST_PUT;
					end
				end
				ST_SWEEP: begin
					swp_cnt_q <= swp_cnt_q + 1'b1;
					if (swp_cnt_q == AW'(WORDS - 1)) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_vld) begin
			item_q <= item;
		end
		if (state_q == ST_EX) begin
			swp_dat_q <= sweep_dat;
			res_rd_q  <= {pins_n[PIN_CS], 1'b1, pins_n[PIN_DOUT]};
			res_en_q  <= en_n;
		end
	end

	always_comb begin
		if (state_q == ST_SWEEP) begin
			wr_addr = swp_cnt_q;
			wr.en   = 1'b1;
			wr.data = swp_dat_q;
		end else begin
			wr_addr = wr1_addr;
			wr.en   = wr1_en && (state_q == ST_EX);
			wr.data = wr1_data;
		end
	end

	assign item_rdy      = (state_q == ST_IDLE);
	assign res.vld       = (state_q == ST_PUT) && slot_free;
	assign res.read_data = res_rd_q;
	assign res.enabled   = res_en_q;

endmodule

[design/microwire_serial_eeprom.sv]
// Top level of the bit-banged serial EEPROM with its output register.
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------
//  cmd     | in  | op (lines, control, read pins), value
//  rsp     | out | read_data (dout, one, cs), enabled
//
// Each beat passes in order through accept, RAM read, execute and hand-off.
// Write-all and erase-all add a sweep that writes every word through the RAM write port.
// Reset clears the valid bits of the store at once; no clearing pass is needed.
// A new beat is taken while the previous result still waits in the output register;
// its hand-off waits until that register is free.
`timescale 1ns / 1ps
`include "microwire_serial_eeprom_macros.svh"
module microwire_serial_eeprom #(
	parameter int WORDS = mwee_pkg::WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mwee_in_if.sink     cmd,
	mwee_out_if.source  rsp
);
	import mwee_pkg::*;

	localparam int AW = $clog2(WORDS);

	item_t         item;
	logic          item_rdy;
	logic          slot_free;
	res_t          res;
	logic [AW-1:0] rd_addr;
	logic [15:0]   rd_data;
	logic [AW-1:0] wr_addr;
	wr_t           wr;
	logic          rsp_vld_q;
	logic [2:0]    rsp_rd_q;
	logic          rsp_en_q;

	assign item.op    = cmd.op;
	assign item.value = cmd.value;
	assign cmd.ready  = item_rdy;
	assign slot_free  = !rsp_vld_q || rsp.ready;

	mwee_ctrl #(.WORDS(WORDS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_vld  (cmd.valid),
		.item      (item),
		.item_rdy  (item_rdy),
		.slot_free (slot_free),
		.res       (res),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_addr   (wr_addr),
		.wr        (wr)
	);

	mwee_store #(.WORDS(WORDS)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_addr (wr_addr),
		.wr      (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (res.vld) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			rsp_rd_q <= res.read_data;
			rsp_en_q <= res.enabled;
		end
	end

	assign rsp.valid     = rsp_vld_q;
	assign rsp.read_data = rsp_rd_q;
	assign rsp.enabled   = rsp_en_q;

	// Only one beat is in flight at a time.
	`MWEE_ASSERT_NXT(a_one_in_flight, cmd.valid && cmd.ready, !cmd.ready, "second beat taken in flight")
	// The input side reopens only once the result has been handed to the output register.
	`MWEE_ASSERT_IMP(a_ready_after_result, $rose(cmd.ready), $past(res.vld), "ready without result")
	// A handed-off result always finds the output register free.
	`MWEE_ASSERT_NXT(a_result_lands, res.vld, rsp.valid, "result lost at hand-off")

endmodule
